// ----- rtl/gqvg_pkg.sv -----
// Shared types, codes and saturation helper for the glyph quad vertex generator.
package gqvg_pkg;

  localparam int DEFAULT_MAX_SAMPLERS = 16;

  localparam int COORD_W = 32;
  localparam int RECIP_W = 24;
  localparam int QUADS_W = 16;
  localparam int UV_W    = 16;
  localparam int SLOT_W  = 4;
  localparam int TOTAL_W = 19;
  localparam int FAULT_W = 2;
  localparam int SAT_W   = 48;

  localparam logic [TOTAL_W-1:0] INDICES_PER_QUAD = 19'd6;

  // Fault codes
  localparam logic [FAULT_W-1:0] FAULT_NONE       = 2'd0;
  localparam logic [FAULT_W-1:0] FAULT_TABLE_FULL = 2'd1;
  localparam logic [FAULT_W-1:0] FAULT_BUDGET     = 2'd2;

  localparam logic [1:0] CORNER_FIRST = 2'd0;
  localparam logic [1:0] CORNER_LAST  = 2'd3;

  // Configuration register indexes
  localparam logic [1:0] REG_RECIP_X   = 2'd0;
  localparam logic [1:0] REG_RECIP_Y   = 2'd1;
  localparam logic [1:0] REG_MAX_QUADS = 2'd2;

  typedef struct packed {
    logic [SLOT_W-1:0]  slot;
    logic [FAULT_W-1:0] fault;
    logic [TOTAL_W-1:0] total;
  } slot_res_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] x0;
    logic signed [COORD_W-1:0] y0;
    logic signed [COORD_W-1:0] y1;
    logic signed [COORD_W-1:0] sw;
    logic [4*UV_W-1:0]         uv;
    slot_res_t                 res;
  } stage3_t;

  localparam logic signed [SAT_W-1:0] S32_MAX = 48'sd2147483647;
  localparam logic signed [SAT_W-1:0] S32_MIN = -48'sd2147483648;

  function automatic logic signed [COORD_W-1:0] sat32(input logic signed [SAT_W-1:0] v);
    logic signed [COORD_W-1:0] r;
    if (v > S32_MAX) begin
      r = 32'sh7FFFFFFF;
    end else if (v < S32_MIN) begin
      r = 32'sh80000000;
    end else begin
      r = v[COORD_W-1:0];
    end
    return r;
  endfunction

endpackage

// ----- rtl/gqvg_scale.sv -----
// Signed Q16.16 by unsigned Q8.16 scaling with floor and 32-bit saturation.
module gqvg_scale (
  input  logic signed [gqvg_pkg::COORD_W-1:0] a,
  input  logic [gqvg_pkg::RECIP_W-1:0]        r,
  output logic signed [gqvg_pkg::COORD_W-1:0] q
);

  logic signed [gqvg_pkg::RECIP_W:0]                   r_s;
  logic signed [gqvg_pkg::COORD_W+gqvg_pkg::RECIP_W:0] prod;
  logic signed [gqvg_pkg::COORD_W+gqvg_pkg::RECIP_W-16:0] shifted;

  assign r_s  = {1'b0, r};
  assign prod = a * r_s;
  // Dropping the low 16 bits of a two's complement product floors it
  assign shifted = prod[gqvg_pkg::COORD_W+gqvg_pkg::RECIP_W:16];
  assign q = gqvg_pkg::sat32(gqvg_pkg::SAT_W'(shifted));

endmodule

// ----- rtl/gqvg_slot_table.sv -----
// Texture-id to sampler slot table with slot allocation and quad budget check.
module gqvg_slot_table #(
  parameter int MAX_SAMPLERS = gqvg_pkg::DEFAULT_MAX_SAMPLERS
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           en,
  input  logic                           new_batch,
  input  logic [31:0]                    texture_id,
  input  logic [gqvg_pkg::QUADS_W-1:0]   max_quads,
  output gqvg_pkg::slot_res_t            res
);

  localparam int IDX_W = (MAX_SAMPLERS > 1) ? $clog2(MAX_SAMPLERS) : 1;
  localparam int CNT_W = $clog2(MAX_SAMPLERS + 1);

  logic [31:0]                  tab [MAX_SAMPLERS];
  logic [CNT_W-1:0]             slots_used;
  logic [gqvg_pkg::QUADS_W-1:0] quad_count;

  logic [CNT_W-1:0]             slots_eff;
  logic [gqvg_pkg::QUADS_W-1:0] quads_eff;
  logic [gqvg_pkg::QUADS_W-1:0] quads_next;
  logic                         hit;
  logic [IDX_W-1:0]             hit_idx;
  logic [IDX_W-1:0]             slot;
  logic [gqvg_pkg::FAULT_W-1:0] fault;
  logic                         alloc;

  assign slots_eff = new_batch ? '0 : slots_used;
  assign quads_eff = new_batch ? '0 : quad_count;

  // Lowest matching live entry wins
  always_comb begin
    hit     = 1'b0;
    hit_idx = '0;
    for (int i = 0; i < MAX_SAMPLERS; i++) begin
      if (!hit && (CNT_W'(i) < slots_eff) && (tab[i] == texture_id)) begin
        hit     = 1'b1;
        hit_idx = IDX_W'(i);
      end
    end
  end

  always_comb begin
    if (!hit && (slots_eff == CNT_W'(MAX_SAMPLERS))) begin
      fault = gqvg_pkg::FAULT_TABLE_FULL;
    end else if (quads_eff >= max_quads) begin
      fault = gqvg_pkg::FAULT_BUDGET;
    end else begin
      fault = gqvg_pkg::FAULT_NONE;
    end
  end

  assign alloc      = (fault == gqvg_pkg::FAULT_NONE) && !hit;
  assign slot       = hit ? hit_idx : slots_eff[IDX_W-1:0];
  assign quads_next = (fault == gqvg_pkg::FAULT_NONE) ? quads_eff + 1'b1 : quads_eff;

  always_comb begin
    res.fault = fault;
    res.slot  = (fault == gqvg_pkg::FAULT_NONE) ? gqvg_pkg::SLOT_W'(slot) : '0;
    res.total = gqvg_pkg::TOTAL_W'(quads_next) * gqvg_pkg::INDICES_PER_QUAD;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slots_used <= '0;
      quad_count <= '0;
    end else if (en) begin
      slots_used <= alloc ? slots_eff + 1'b1 : slots_eff;
      quad_count <= quads_next;
    end
  end

  always_ff @(posedge clk) begin
    if (en && alloc) begin
      tab[slots_eff[IDX_W-1:0]] <= texture_id;
    end
  end

endmodule

// ----- rtl/gqvg_vertex_emitter.sv -----
// Output register that holds one quad and sends its corners one per transfer, or one item if faulted.
module gqvg_vertex_emitter (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    load_valid,
  output logic                    load_ready,
  input  gqvg_pkg::stage3_t       load,
  output logic                    m_axis_tvalid,
  input  logic                    m_axis_tready,
  output logic [119:0]            m_axis_tdata,  // vert_x, vert_y, tex_u, tex_v, sampler_slot, index_total
  output logic [3:0]              m_axis_tuser,  // corner, fault
  output logic                    m_axis_tlast
);

  logic                                busy;
  logic [1:0]                          corner;
  logic signed [gqvg_pkg::COORD_W-1:0] x0, x1, y0, y1;
  logic [gqvg_pkg::UV_W-1:0]           u0, v0, u1, v1;
  logic [gqvg_pkg::SLOT_W-1:0]         slot;
  logic [gqvg_pkg::TOTAL_W-1:0]        total;
  logic [gqvg_pkg::FAULT_W-1:0]        fault;

  logic                                take;
  logic                                last_beat;
  logic                                ok;
  logic signed [gqvg_pkg::COORD_W-1:0] x1_calc;
  logic signed [gqvg_pkg::COORD_W-1:0] vx, vy;
  logic [gqvg_pkg::UV_W-1:0]           tu, tv;

  assign take       = m_axis_tvalid && m_axis_tready;
  assign last_beat  = (fault != gqvg_pkg::FAULT_NONE) || (corner == gqvg_pkg::CORNER_LAST);
  assign load_ready = !busy || (take && last_beat);
  assign ok         = (load.res.fault == gqvg_pkg::FAULT_NONE);
  assign x1_calc    = gqvg_pkg::sat32(gqvg_pkg::SAT_W'(load.x0) + gqvg_pkg::SAT_W'(load.sw));

  always_ff @(posedge clk) begin
    if (rst) begin
      busy   <= 1'b0;
      corner <= gqvg_pkg::CORNER_FIRST;
    end else if (load_valid && load_ready) begin
      busy   <= 1'b1;
      corner <= gqvg_pkg::CORNER_FIRST;
    end else if (take && last_beat) begin
      busy   <= 1'b0;
    end else if (take) begin
      corner <= corner + 2'd1;
    end
  end

  // Fault items carry only the index total and the fault code
  always_ff @(posedge clk) begin
    if (load_valid && load_ready) begin
      x0    <= ok ? load.x0 : '0;
      x1    <= ok ? x1_calc : '0;
      y0    <= ok ? load.y0 : '0;
      y1    <= ok ? load.y1 : '0;
      u0    <= ok ? load.uv[15:0]  : '0;
      v0    <= ok ? load.uv[31:16] : '0;
      u1    <= ok ? load.uv[47:32] : '0;
      v1    <= ok ? load.uv[63:48] : '0;
      slot  <= load.res.slot;
      total <= load.res.total;
      fault <= load.res.fault;
    end
  end

  // Corner order: (x0,y0) (x0,y1) (x1,y1) (x1,y0)
  assign vx = corner[1] ? x1 : x0;
  assign vy = (corner[1] ^ corner[0]) ? y1 : y0;
  assign tu = corner[1] ? u1 : u0;
  assign tv = (corner[1] ^ corner[0]) ? v1 : v0;

  assign m_axis_tvalid = busy;
  assign m_axis_tdata  = {1'b0, total, slot, tv, tu, vy, vx};
  assign m_axis_tuser  = {fault, corner};
  assign m_axis_tlast  = (corner == gqvg_pkg::CORNER_LAST);

endmodule

// ----- rtl/glyph_quad_vertex_generator_unit.sv -----
// Glyph quad vertex generator: glyph in, four textured quad corner vertices out.
// First vertex: offered after the stage 0 to 3 and emitter load registers, stalls permitting.
// Throughput: one vertex per cycle while m_axis_tready is high; four per glyph, one if faulted.
// The single output port of the vertex emitter sets that rate; the 4-stage pipe ahead
// of it keeps taking glyphs while a quad drains.
// Reset (rst, synchronous, active high) clears pipe valids, pen, slot and quad counts and
// loads the scale and budget registers; the slot table has no clearing pass.
module glyph_quad_vertex_generator_unit #(
  parameter int MAX_SAMPLERS = gqvg_pkg::DEFAULT_MAX_SAMPLERS
) (
  input  logic         clk,
  input  logic         rst,
  // Glyph input
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // texture_id, origin_x, origin_y, bearing_x, bearing_y, glyph_width, glyph_height,
  // pen_step, uv_rect, two zero pad bits
  input  logic [319:0] s_axis_tdata,
  input  logic [1:0]   s_axis_tuser,  // new_batch, first_glyph
  // Configuration write
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [1:0]   cfg_index,
  input  logic [23:0]  cfg_data,
  // Vertex output
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // vert_x, vert_y, tex_u, tex_v, sampler_slot, index_total, one zero pad bit
  output logic [119:0] m_axis_tdata,
  output logic [3:0]   m_axis_tuser,  // corner, fault
  output logic         m_axis_tlast
);

  localparam int CW = gqvg_pkg::COORD_W;

  typedef struct packed {
    logic                 new_batch;
    logic                 first_glyph;
    logic [31:0]          texture_id;
    logic signed [CW-1:0] origin_x;
    logic signed [CW-1:0] origin_y;
    logic signed [CW-1:0] bearing_x;
    logic signed [CW-1:0] bearing_y;
    logic [30:0]          glyph_width;
    logic [30:0]          glyph_height;
    logic signed [CW-1:0] pen_step;
    logic [63:0]          uv_rect;
  } glyph_t;

  // ---------------------------------------------------------------------------
  // Configuration registers. Writes are to arrive only while the block is idle; not enforced here.
  // ---------------------------------------------------------------------------
  logic [gqvg_pkg::RECIP_W-1:0] recip_scale_x;
  logic [gqvg_pkg::RECIP_W-1:0] recip_scale_y;
  logic [gqvg_pkg::QUADS_W-1:0] max_quads;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      recip_scale_x <= 24'd65536;
      recip_scale_y <= 24'd65536;
      max_quads     <= 16'd65535;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        gqvg_pkg::REG_RECIP_X:   recip_scale_x <= cfg_data;
        gqvg_pkg::REG_RECIP_Y:   recip_scale_y <= cfg_data;
        gqvg_pkg::REG_MAX_QUADS: max_quads     <= cfg_data[gqvg_pkg::QUADS_W-1:0];
        default: ;  // unmapped index: drop the write
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Pipe handshake: each stage moves when the next one is empty or moving.
  // ---------------------------------------------------------------------------
  logic v0, v1, v2, v3;
  logic adv0, adv1, adv2, adv3;
  logic emit_ready;

  assign adv3 = v3 && emit_ready;
  assign adv2 = v2 && (!v3 || adv3);
  assign adv1 = v1 && (!v2 || adv2);
  assign adv0 = v0 && (!v1 || adv1);
  assign s_axis_tready = !v0 || adv0;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        v0 <= 1'b1;
      end else if (adv0) begin
        v0 <= 1'b0;
      end
      if (adv0) begin
        v1 <= 1'b1;
      end else if (adv1) begin
        v1 <= 1'b0;
      end
      if (adv1) begin
        v2 <= 1'b1;
      end else if (adv2) begin
        v2 <= 1'b0;
      end
      if (adv2) begin
        v3 <= 1'b1;
      end else if (adv3) begin
        v3 <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 0: input register, unpack the transfer.
  // ---------------------------------------------------------------------------
  glyph_t g;

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      g.new_batch    <= s_axis_tuser[0];
      g.first_glyph  <= s_axis_tuser[1];
      g.texture_id   <= s_axis_tdata[31:0];
      g.origin_x     <= s_axis_tdata[63:32];
      g.origin_y     <= s_axis_tdata[95:64];
      g.bearing_x    <= s_axis_tdata[127:96];
      g.bearing_y    <= s_axis_tdata[159:128];
      g.glyph_width  <= s_axis_tdata[190:160];
      g.glyph_height <= s_axis_tdata[221:191];
      g.pen_step     <= s_axis_tdata[253:222];
      g.uv_rect      <= s_axis_tdata[317:254];
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 1: slot lookup and budget check (state advances here, in order),
  // and the five scaled terms, one multiplier each.
  // ---------------------------------------------------------------------------
  gqvg_pkg::slot_res_t  res_c;
  logic signed [CW-1:0] sbx_c, sby_c, sw_c, sh_c, sps_c;

  gqvg_slot_table #(
    .MAX_SAMPLERS (MAX_SAMPLERS)
  ) u_slot_table (
    .clk        (clk),
    .rst        (rst),
    .en         (adv0),
    .new_batch  (g.new_batch),
    .texture_id (g.texture_id),
    .max_quads  (max_quads),
    .res        (res_c)
  );

  gqvg_scale u_scale_bx (.a(g.bearing_x), .r(recip_scale_x), .q(sbx_c));
  gqvg_scale u_scale_by (.a(g.bearing_y), .r(recip_scale_y), .q(sby_c));
  gqvg_scale u_scale_w  (.a($signed({1'b0, g.glyph_width})),  .r(recip_scale_x), .q(sw_c));
  gqvg_scale u_scale_h  (.a($signed({1'b0, g.glyph_height})), .r(recip_scale_y), .q(sh_c));
  gqvg_scale u_scale_ps (.a(g.pen_step), .r(recip_scale_x), .q(sps_c));

  gqvg_pkg::slot_res_t  s1_res;
  logic signed [CW-1:0] s1_ox, s1_oy, s1_sbx, s1_sby, s1_sw, s1_sh, s1_sps;
  logic [63:0]          s1_uv;
  logic                 s1_first;

  always_ff @(posedge clk) begin
    if (adv0) begin
      s1_res   <= res_c;
      s1_ox    <= g.origin_x;
      s1_oy    <= g.origin_y;
      s1_sbx   <= sbx_c;
      s1_sby   <= sby_c;
      s1_sw    <= sw_c;
      s1_sh    <= sh_c;
      s1_sps   <= sps_c;
      s1_uv    <= g.uv_rect;
      s1_first <= g.first_glyph;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 2: origin plus scaled bearing on both axes.
  // ---------------------------------------------------------------------------
  gqvg_pkg::slot_res_t  s2_res;
  logic signed [CW-1:0] s2_xa, s2_y0, s2_sw, s2_sh, s2_sps;
  logic [63:0]          s2_uv;
  logic                 s2_first;

  always_ff @(posedge clk) begin
    if (adv1) begin
      s2_res   <= s1_res;
      s2_xa    <= gqvg_pkg::sat32(gqvg_pkg::SAT_W'(s1_ox) + gqvg_pkg::SAT_W'(s1_sbx));
      s2_y0    <= gqvg_pkg::sat32(gqvg_pkg::SAT_W'(s1_oy) + gqvg_pkg::SAT_W'(s1_sby));
      s2_sw    <= s1_sw;
      s2_sh    <= s1_sh;
      s2_sps   <= s1_sps;
      s2_uv    <= s1_uv;
      s2_first <= s1_first;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 3: add the pen, drop the glyph height, advance the pen.
  // A faulted glyph keeps the pen, apart from the first-glyph clear.
  // ---------------------------------------------------------------------------
  logic signed [CW-1:0] pen_advance;
  logic signed [CW-1:0] pen_base;
  gqvg_pkg::stage3_t    s3;

  assign pen_base = s2_first ? '0 : pen_advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      pen_advance <= '0;
    end else if (adv2) begin
      pen_advance <= (s2_res.fault == gqvg_pkg::FAULT_NONE)
                   ? gqvg_pkg::sat32(gqvg_pkg::SAT_W'(pen_base) + gqvg_pkg::SAT_W'(s2_sps))
                   : pen_base;
    end
  end

  always_ff @(posedge clk) begin
    if (adv2) begin
      s3.x0  <= gqvg_pkg::sat32(gqvg_pkg::SAT_W'(s2_xa) + gqvg_pkg::SAT_W'(pen_base));
      s3.y0  <= s2_y0;
      s3.y1  <= gqvg_pkg::sat32(gqvg_pkg::SAT_W'(s2_y0) - gqvg_pkg::SAT_W'(s2_sh));
      s3.sw  <= s2_sw;
      s3.uv  <= s2_uv;
      s3.res <= s2_res;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 4: right edge on load, then four corner transfers, or one for a faulted glyph.
  // ---------------------------------------------------------------------------
  gqvg_vertex_emitter u_emitter (
    .clk           (clk),
    .rst           (rst),
    .load_valid    (v3),
    .load_ready    (emit_ready),
    .load          (s3),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule
